/* rtl/pesl_pkg.sv */
package pesl_pkg;

    localparam int NAME_SLOTS  = 4;
    localparam int ADDR_BITS   = 64;
    localparam int NAME_BYTES  = 8;
    localparam int NAME_W      = 8 * NAME_BYTES;
    localparam int SLOT_MASK_W = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int ACTIVE_W    = 3;

    localparam logic [63:0] ADDR_MAX = {64{1'b1}} >> (64 - ADDR_BITS);

    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);
    localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);
    localparam int OBUF_DEPTH = 2;
    localparam int OBUF_PTR_W = $clog2(OBUF_DEPTH);
    localparam int OBUF_CNT_W = $clog2(OBUF_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WANTED_0,
        REG_WANTED_1,
        REG_WANTED_2,
        REG_WANTED_3,
        REG_NAMES_IN_USE,
        REG_LOAD_BASE
    } cfg_reg_t;

    typedef struct packed {
        logic [NAME_W-1:0] entry_name;
        logic [31:0]       region_size;
        logic [31:0]       region_vaddr;
        logic [31:0]       raw_offset;
        logic              last_entry;
    } in_item_t;

    typedef struct packed {
        logic [SLOT_MASK_W-1:0] slot_mask;
        logic [31:0]            found_size;
        logic [31:0]            found_file_offset;
        logic [31:0]            found_memory_offset;
    } out_item_t;

    typedef struct packed {
        logic [NAME_SLOTS-1:0][NAME_W-1:0] wanted_name;
        logic [ACTIVE_W-1:0]               names_in_use;
        logic [63:0]                       load_base;
    } cfg_t;

    // classified entry handed from front to back
    typedef struct packed {
        logic [NAME_SLOTS-1:0] cand;
        logic                  last;
        logic [31:0]           size;
        logic [31:0]           vaddr;
        logic [31:0]           raw;
    } class_t;

    // bytes agree up to and including the first zero byte, or in all bytes
    function automatic logic names_match(input logic [NAME_W-1:0] x,
                                         input logic [NAME_W-1:0] y);
        logic ok;
        logic done;
        ok   = 1'b1;
        done = 1'b0;
        for (int i = 0; i < NAME_BYTES; i++) begin
            if (!done) begin
                if (x[8*i +: 8] != y[8*i +: 8]) begin
                    ok   = 1'b0;
                    done = 1'b1;
                end
                else if (x[8*i +: 8] == 8'd0) begin
                    done = 1'b1;
                end
            end
        end
        return ok;
    endfunction

endpackage

/* rtl/pe_section_locator.sv */
// Section table lookup: one section entry request is taken per clock while
// full is low, and at most one result request comes out per entry that fills
// at least one still-open wanted slot. The front compares the entry name with
// all wanted names and runs the overflow checks in the accept cycle; a
// 4-deep queue then feeds the back, which updates the per-slot found flags
// and writes results into a 2-deep result buffer. Sustained rate is one entry
// per cycle while the result buffer has room, set by the found-flag update in
// the back; an entry is registered in the queue and its result in the result
// buffer before the result shows. Configuration writes are taken every cycle
// (cfg_ready is always high) and must only happen while no entry is in flight.
module pe_section_locator (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  pesl_pkg::in_item_t                   entry,
    output logic                                 empty,
    input  logic                                 pop,
    output pesl_pkg::out_item_t                  result,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pesl_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [63:0]                          cfg_data
);
    import pesl_pkg::*;

    logic [NAME_SLOTS-1:0][NAME_W-1:0] wanted_reg;
    logic [NAME_SLOTS-1:0][NAME_W-1:0] wanted_next;
    logic [ACTIVE_W-1:0]               in_use_reg;
    logic [ACTIVE_W-1:0]               in_use_next;
    logic [63:0]                       base_reg;
    logic [63:0]                       base_next;
    logic                              cfg_wr;
    cfg_t                              cfg;
    class_t                            cls;
    class_t                            q_data;
    logic                              q_empty;
    logic                              q_pop;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_comb
    begin
        wanted_next = wanted_reg;
        in_use_next = in_use_reg;
        base_next   = base_reg;
        if (cfg_wr) begin
            case (cfg_index)
                REG_WANTED_0:     wanted_next[0] = cfg_data;
                REG_WANTED_1:     wanted_next[1] = cfg_data;
                REG_WANTED_2:     wanted_next[2] = cfg_data;
                REG_WANTED_3:     wanted_next[3] = cfg_data;
                REG_NAMES_IN_USE: in_use_next    = cfg_data[ACTIVE_W-1:0];
                REG_LOAD_BASE:    base_next      = cfg_data;
                default:          base_next      = base_reg;
            endcase
        end
        cfg.wanted_name  = wanted_reg;
        cfg.names_in_use = in_use_reg;
        cfg.load_base    = base_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wanted_reg <= '0;
            in_use_reg <= '0;
            base_reg   <= '0;
        end
        else begin
            wanted_reg <= wanted_next;
            in_use_reg <= in_use_next;
            base_reg   <= base_next;
        end
    end

    pesl_front u_front (
        .entry (entry),
        .cfg   (cfg),
        .cls   (cls)
    );

    pesl_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (push),
        .wr_data (cls),
        .full    (full),
        .rd      (q_pop),
        .rd_data (q_data),
        .empty   (q_empty)
    );

    pesl_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_data  (q_data),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

/* rtl/pesl_front.sv */
module pesl_front (
    input  pesl_pkg::in_item_t entry,
    input  pesl_pkg::cfg_t     cfg,
    output pesl_pkg::class_t   cls
);
    import pesl_pkg::*;

    logic [63:0]         size64;
    logic [63:0]         vaddr64;
    logic [63:0]         raw64;
    logic [63:0]         lim_raw;
    logic [63:0]         lim_va;
    logic [63:0]         lim_base;
    logic                entry_ok;
    logic [ACTIVE_W-1:0] active;

    always_comb
    begin
        size64   = 64'(entry.region_size);
        vaddr64  = 64'(entry.region_vaddr);
        raw64    = 64'(entry.raw_offset);
        lim_raw  = ADDR_MAX - raw64;
        lim_va   = ADDR_MAX - vaddr64;
        lim_base = lim_va - cfg.load_base;
        entry_ok = (size64 <= lim_raw) && (size64 <= lim_va);
        // base check only when a load base is set; underflow of lim_base is
        // masked by the first compare
        if (cfg.load_base != 64'd0) begin
            if ((cfg.load_base > lim_va) || (vaddr64 > lim_base))
            begin
                entry_ok = 1'b0;
            end
        end

        if (cfg.names_in_use > ACTIVE_W'(NAME_SLOTS))
        begin
            active = ACTIVE_W'(NAME_SLOTS);
        end
        else
        begin
            active = cfg.names_in_use;
        end

        for (int k = 0; k < NAME_SLOTS; k++) begin
            cls.cand[k] = entry_ok && (ACTIVE_W'(k) < active) &&
                          names_match(entry.entry_name, cfg.wanted_name[k]);
        end
        cls.last  = entry.last_entry;
        cls.size  = entry.region_size;
        cls.vaddr = entry.region_vaddr;
        cls.raw   = entry.raw_offset;
    end

endmodule

/* rtl/pesl_queue.sv */
module pesl_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr,
    input  pesl_pkg::class_t wr_data,
    output logic             full,
    input  logic             rd,
    output pesl_pkg::class_t rd_data,
    output logic             empty
);
    import pesl_pkg::*;

    class_t             mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg;
    logic [Q_CNT_W-1:0] count_next;
    logic               do_wr;
    logic               do_rd;

    assign full    = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = wr && !full;
    assign do_rd   = rd && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd) begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_wr && do_rd) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= Q_CNT_W'(Q_DEPTH))
        else $error("queue count out of range");
    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (do_wr && !do_rd) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not advance on write");
    a_ptrs_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers differ while empty");
`endif

endmodule

/* rtl/pesl_back.sv */
module pesl_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  pesl_pkg::class_t    q_data,
    output logic                q_pop,
    output logic                empty,
    input  logic                pop,
    output pesl_pkg::out_item_t result
);
    import pesl_pkg::*;

    logic [NAME_SLOTS-1:0] found_reg;
    logic [NAME_SLOTS-1:0] found_next;
    logic [NAME_SLOTS-1:0] mask;
    logic                  res_push;
    logic                  res_pop;
    logic                  has_space;
    out_item_t             res_item;

    out_item_t             obuf_reg [OBUF_DEPTH];
    logic [OBUF_PTR_W-1:0] owr_ptr_reg;
    logic [OBUF_PTR_W-1:0] owr_ptr_next;
    logic [OBUF_PTR_W-1:0] ord_ptr_reg;
    logic [OBUF_PTR_W-1:0] ord_ptr_next;
    logic [OBUF_CNT_W-1:0] ocnt_reg;
    logic [OBUF_CNT_W-1:0] ocnt_next;

    assign empty     = (ocnt_reg == '0);
    assign result    = obuf_reg[ord_ptr_reg];
    assign res_pop   = pop && !empty;
    assign has_space = (ocnt_reg != OBUF_CNT_W'(OBUF_DEPTH)) || res_pop;
    assign q_pop     = !q_empty && has_space;
    assign mask      = q_data.cand & ~found_reg;
    assign res_push  = q_pop && (mask != '0);

    always_comb
    begin
        res_item.slot_mask           = SLOT_MASK_W'(mask);
        res_item.found_size          = q_data.size;
        res_item.found_file_offset   = q_data.raw;
        res_item.found_memory_offset = q_data.vaddr;

        found_next = found_reg;
        if (q_pop) begin
            found_next = q_data.last ? '0 : (found_reg | mask);
        end

        owr_ptr_next = owr_ptr_reg;
        ord_ptr_next = ord_ptr_reg;
        ocnt_next    = ocnt_reg;
        if (res_push) begin
            owr_ptr_next = (owr_ptr_reg == OBUF_PTR_W'(OBUF_DEPTH - 1)) ? '0
                         : owr_ptr_reg + 1'b1;
        end
        if (res_pop) begin
            ord_ptr_next = (ord_ptr_reg == OBUF_PTR_W'(OBUF_DEPTH - 1)) ? '0
                         : ord_ptr_reg + 1'b1;
        end
        if (res_push && !res_pop) begin
            ocnt_next = ocnt_reg + 1'b1;
        end
        else if (!res_push && res_pop) begin
            ocnt_next = ocnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            found_reg   <= '0;
            owr_ptr_reg <= '0;
            ord_ptr_reg <= '0;
            ocnt_reg    <= '0;
        end
        else begin
            found_reg   <= found_next;
            owr_ptr_reg <= owr_ptr_next;
            ord_ptr_reg <= ord_ptr_next;
            ocnt_reg    <= ocnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push) begin
            obuf_reg[owr_ptr_reg] <= res_item;
        end
    end

`ifndef SYNTHESIS
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && q_data.last) |=> (found_reg == '0))
        else $error("found flags not cleared after last entry");
    a_flags_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && !q_data.last) |=> ((found_reg & $past(found_reg)) == $past(found_reg)))
        else $error("found flag dropped inside a table");
    a_mask_set: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.slot_mask != '0))
        else $error("result with empty slot mask");
    a_obuf_range: assert property (@(posedge clk) disable iff (!rst_n)
        ocnt_reg <= OBUF_CNT_W'(OBUF_DEPTH))
        else $error("result buffer count out of range");
`endif

endmodule

/* tb/sv/tb_pe_section_locator.sv */
// Holds the wanted names, slot count, load base and per-slot found flags,
// and keeps the results that accepted section entries should produce.
class section_scoreboard;
    logic [63:0]                     wanted [pesl_pkg::NAME_SLOTS];
    logic [pesl_pkg::ACTIVE_W-1:0]   slots_in_use;
    logic [63:0]                     base_addr;
    logic [pesl_pkg::NAME_SLOTS-1:0] slot_filled;
    pesl_pkg::out_item_t             awaited_q[$];
    int                              errors;

    function new();
        foreach (wanted[i]) wanted[i] = '0;
        slots_in_use = '0;
        base_addr    = '0;
        slot_filled  = '0;
        errors       = 0;
    endfunction

    function void set_reg(pesl_pkg::cfg_reg_t idx, logic [63:0] value);
        case (idx)
            pesl_pkg::REG_WANTED_0:     wanted[0] = value;
            pesl_pkg::REG_WANTED_1:     wanted[1] = value;
            pesl_pkg::REG_WANTED_2:     wanted[2] = value;
            pesl_pkg::REG_WANTED_3:     wanted[3] = value;
            pesl_pkg::REG_NAMES_IN_USE: slots_in_use = value[pesl_pkg::ACTIVE_W-1:0];
            pesl_pkg::REG_LOAD_BASE:    base_addr = value;
            default: ;
        endcase
    endfunction

    // bytes must agree up to the wanted name's terminator (all 8 if none)
    function bit same_name(logic [63:0] got, logic [63:0] want);
        int term;
        term = 7;
        for (int i = 7; i >= 0; i--)
            if (want[8*i +: 8] == 8'h00) term = i;
        for (int i = 0; i <= term; i++)
            if (got[8*i +: 8] != want[8*i +: 8]) return 1'b0;
        return 1'b1;
    endfunction

    function bit fits_memory(logic [31:0] size, logic [31:0] vaddr, logic [31:0] raw);
        logic [63:0] top;
        logic [63:0] room;
        top = {64{1'b1}} >> (64 - pesl_pkg::ADDR_BITS);
        if ({32'd0, size} > top - {32'd0, raw}) return 1'b0;
        room = top - {32'd0, vaddr};
        if ({32'd0, size} > room) return 1'b0;
        if (base_addr != 64'd0) begin
            if (base_addr > room) return 1'b0;
            if ({32'd0, vaddr} > room - base_addr) return 1'b0;
        end
        return 1'b1;
    endfunction

    function void note_entry(pesl_pkg::in_item_t e);
        int                               active;
        logic [pesl_pkg::SLOT_MASK_W-1:0] fill;
        pesl_pkg::out_item_t              want;
        active = (slots_in_use > pesl_pkg::NAME_SLOTS) ? pesl_pkg::NAME_SLOTS : slots_in_use;
        fill   = '0;
        if (fits_memory(e.region_size, e.region_vaddr, e.raw_offset))
            for (int k = 0; k < active; k++)
                if (!slot_filled[k] && same_name(e.entry_name, wanted[k])) fill[k] = 1'b1;
        if (fill != '0) begin
            slot_filled              = slot_filled | fill;
            want.slot_mask           = fill;
            want.found_size          = e.region_size;
            want.found_file_offset   = e.raw_offset;
            want.found_memory_offset = e.region_vaddr;
            awaited_q.push_back(want);
        end
        if (e.last_entry) slot_filled = '0;
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
        errors++;
    endtask

    task check_result(pesl_pkg::out_item_t got);
        pesl_pkg::out_item_t want;
        if (awaited_q.size() == 0) begin
            report_mismatch("unexpected result, slot_mask", got.slot_mask, '0);
            return;
        end
        want = awaited_q.pop_front();
        if (got.slot_mask !== want.slot_mask)
            report_mismatch("slot_mask", got.slot_mask, want.slot_mask);
        if (got.found_size !== want.found_size)
            report_mismatch("found_size", got.found_size, want.found_size);
        if (got.found_file_offset !== want.found_file_offset)
            report_mismatch("found_file_offset", got.found_file_offset,
                            want.found_file_offset);
        if (got.found_memory_offset !== want.found_memory_offset)
            report_mismatch("found_memory_offset", got.found_memory_offset,
                            want.found_memory_offset);
    endtask

    function int outstanding();
        return awaited_q.size();
    endfunction
endclass

module tb_pe_section_locator;
    import pesl_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = 16;

    logic                 clk;
    logic                 rst_n;
    logic                 push;
    logic                 full;
    in_item_t             entry;
    logic                 empty;
    logic                 pop;
    out_item_t            result;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [63:0]          cfg_data;

    int                   tx_gap_pct = 0;
    int                   rx_stall_pct = 0;
    int                   hold_left = 0;
    int                   cycle_count = 0;
    logic [63:0]          cur_wanted [4];
    section_scoreboard    sb;

    pe_section_locator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .entry     (entry),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** pe_section_locator: FAILED **");
            $finish;
        end
    end

    // long receiver hold-off, counted down here
    always @(posedge clk)
        if (hold_left > 0) hold_left <= hold_left - 1;

    always @(posedge clk)
        pop <= (hold_left == 0) && ($urandom_range(99) >= rx_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n) begin
            if (push && !full) sb.note_entry(entry);
            if (pop && !empty) sb.check_result(result);
        end
    end

    function automatic logic [63:0] pack_name(string s);
        logic [63:0] v;
        v = '0;
        for (int i = 0; i < s.len() && i < 8; i++) v[8*i +: 8] = s[i];
        return v;
    endfunction

    function automatic in_item_t mk(logic [63:0] name, logic [31:0] size,
                                    logic [31:0] vaddr, logic [31:0] raw, logic last);
        in_item_t e;
        e.entry_name   = name;
        e.region_size  = size;
        e.region_vaddr = vaddr;
        e.raw_offset   = raw;
        e.last_entry   = last;
        return e;
    endfunction

    function automatic logic [63:0] random_wanted();
        logic [63:0] v;
        int          r;
        int          len;
        v = '0;
        r = $urandom_range(9);
        if (r == 0) return {64{1'b1}};
        if (r == 1) return 64'd0;
        len = (r < 5) ? 8 : $urandom_range(1, 7);
        for (int i = 0; i < len; i++) v[8*i +: 8] = $urandom_range(1, 255);
        return v;
    endfunction

    // mostly names that hit or nearly hit one of the wanted names
    function automatic logic [63:0] random_entry_name();
        logic [63:0] v;
        int          r;
        int          term;
        int          pos;
        v    = cur_wanted[$urandom_range(3)];
        r    = $urandom_range(99);
        term = 8;
        for (int i = 7; i >= 0; i--)
            if (v[8*i +: 8] == 8'h00) term = i;
        if (r < 45) return v;
        if (r < 60) begin
            for (int i = term + 1; i < 8; i++) v[8*i +: 8] = $urandom_range(255);
            return v;
        end
        if (r < 72) begin
            pos = $urandom_range((term > 7) ? 7 : term);
            v[8*pos +: 8] = v[8*pos +: 8] ^ 8'($urandom_range(1, 255));
            return v;
        end
        if (r < 80) return {32'($urandom), 24'($urandom), 8'h00};
        return {32'($urandom), 32'($urandom)};
    endfunction

    function automatic logic [31:0] pick_field();
        int r;
        r = $urandom_range(99);
        if (r < 40) return $urandom;
        if (r < 70) return $urandom_range(255);
        if (r < 85) return 32'hFFFF_FF00 | $urandom_range(255);
        return 32'h7FFF_FF80 + $urandom_range(255);
    endfunction

    task automatic send_entry(in_item_t e);
        while ($urandom_range(99) < tx_gap_pct) begin
            push <= 1'b0;
            @(posedge clk);
        end
        push  <= 1'b1;
        entry <= e;
        do @(posedge clk); while (full);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, value);
    endtask

    task automatic configure(logic [63:0] w0, logic [63:0] w1, logic [63:0] w2,
                             logic [63:0] w3, logic [ACTIVE_W-1:0] n_use,
                             logic [63:0] base);
        write_reg(REG_WANTED_0, w0);
        write_reg(REG_WANTED_1, w1);
        write_reg(REG_WANTED_2, w2);
        write_reg(REG_WANTED_3, w3);
        write_reg(REG_NAMES_IN_USE, {{(64-ACTIVE_W){1'b0}}, n_use});
        write_reg(REG_LOAD_BASE, base);
        cfg_valid <= 1'b0;
        cur_wanted = '{w0, w1, w2, w3};
    endtask

    // sender stops until every result request is back, then lets the
    // queue drain entries that produce nothing; the first edge lets the
    // monitor note the last accepted request
    task automatic wait_idle();
        push <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    initial
    begin
        logic [ACTIVE_W-1:0] use_list [8];
        logic [63:0]         base;
        int                  tbl_left;
        logic                last;

        push      = 1'b0;
        pop       = 1'b0;
        entry     = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        use_list  = '{3'd4, 3'd1, 3'd7, 3'd3, 3'd0, 3'd2, 3'd4, 3'd5};
        sb        = new();

        do @(posedge clk); while (!rst_n);

        // slot count above the limit, empty wanted name, duplicate wanted name
        configure(pack_name(".text"), {64{1'b1}}, 64'd0, pack_name(".text"),
                  3'd7, 64'd0);
        send_entry(mk(pack_name(".text"), 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 1'b0));
        send_entry(mk(pack_name(".text") | 64'hABCD_0000_0000_0000, 32'd1, 32'd2,
                      32'd3, 1'b0));
        send_entry(mk({64{1'b1}}, 32'd0, 32'hFFFF_FFFF, 32'd0, 1'b0));
        send_entry(mk(64'hFFFF_FFFF_FFFF_FF00, 32'd5, 32'd6, 32'd7, 1'b0));
        send_entry(mk(64'd0, 32'd8, 32'd9, 32'd10, 1'b0));
        send_entry(mk(pack_name(".texu"), 32'd11, 32'd12, 32'd13, 1'b1));
        send_entry(mk(pack_name(".text") | 64'h5A00_0000_0000_0000, 32'h1234,
                      32'h5678, 32'h9ABC, 1'b0));
        send_entry(mk(pack_name(".tex"), 32'd1, 32'd1, 32'd1, 1'b0));
        send_entry(mk(64'hFFFF_FFFF_FFFF_FFFE, 32'd1, 32'd1, 32'd1, 1'b0));
        wait_idle();

        // table left open: found flags survive the register change
        configure(pack_name(".text"), pack_name(".reloc"), pack_name(".data"),
                  {64{1'b1}}, 3'd2, 64'hFFFF_FFFF_0000_0000);
        send_entry(mk(pack_name(".text"), 32'd4, 32'd0, 32'd4, 1'b0));
        send_entry(mk(pack_name(".reloc"), 32'd4, 32'h8000_0000, 32'd4, 1'b0));
        send_entry(mk(pack_name(".reloc"), 32'd4, 32'h7FFF_FFFF, 32'd4, 1'b0));
        send_entry(mk(pack_name(".data"), 32'd4, 32'd0, 32'd4, 1'b1));
        send_entry(mk(pack_name(".text"), 32'd4, 32'h8000_0000, 32'd4, 1'b0));
        send_entry(mk(pack_name(".text"), 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                      32'hFFFF_FFFF, 1'b1));
        wait_idle();

        configure(pack_name(".text"), pack_name(".reloc"), pack_name(".data"),
                  {64{1'b1}}, 3'd1, {64{1'b1}});
        send_entry(mk(pack_name(".text"), 32'd0, 32'd1, 32'd0, 1'b0));
        send_entry(mk(pack_name(".text"), 32'd0, 32'd0, 32'd0, 1'b1));
        wait_idle();

        // no active slots: nothing comes out
        configure(pack_name(".text"), 64'd0, 64'd0, 64'd0, 3'd0, 64'd0);
        send_entry(mk(pack_name(".text"), 32'd1, 32'd2, 32'd3, 1'b0));
        send_entry(mk(64'd0, 32'd1, 32'd2, 32'd3, 1'b1));
        wait_idle();

        // receiver holds off while every entry yields a result: block fills up
        configure(pack_name(".text"), 64'd0, 64'd0, 64'd0, 3'd1, 64'd0);
        tx_gap_pct   <= 0;
        rx_stall_pct <= 0;
        hold_left    <= 80;
        repeat (30)
            send_entry(mk(pack_name(".text"), $urandom, $urandom_range(65535),
                          $urandom, 1'b1));
        wait_idle();

        for (int p = 0; p < 8; p++) begin
            case (p)
                1:       base = {64{1'b1}};
                3:       base = {32'($urandom), 32'($urandom)};
                4:       base = 64'hFFFF_FFFF_0000_0000;
                5:       base = 64'd1;
                7:       base = 64'hFFFF_FFFE_0000_0000 + $urandom;
                default: base = 64'd0;
            endcase
            configure(random_wanted(), random_wanted(), random_wanted(), random_wanted(),
                      use_list[p], base);
            case (p % 4)
                0:       begin tx_gap_pct <= 0;  rx_stall_pct <= 0;  end
                1:       begin tx_gap_pct <= 46; rx_stall_pct <= 0;  end
                2:       begin tx_gap_pct <= 0;  rx_stall_pct <= 46; end
                default: begin tx_gap_pct <= 32; rx_stall_pct <= 32; end
            endcase
            tbl_left = 0;
            for (int i = 0; i < 110; i++) begin
                if (tbl_left == 0) tbl_left = $urandom_range(1, 8);
                last = (tbl_left == 1);
                if ($urandom_range(99) < 3) last = !last;
                tbl_left--;
                send_entry(mk(random_entry_name(), pick_field(), pick_field(),
                              pick_field(), last));
            end
            wait_idle();
        end

        if (sb.errors == 0)
            $display("** pe_section_locator: PASSED **");
        else
            $display("** pe_section_locator: FAILED **");
        $finish;
    end

endmodule

/* sim.f */
rtl/pesl_pkg.sv
rtl/pesl_front.sv
rtl/pesl_queue.sv
rtl/pesl_back.sv
rtl/pe_section_locator.sv
tb/sv/tb_pe_section_locator.sv
